[rtl/core/scvg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scvg_pkg
// Types, constants and trig helpers shared by the sphere cell vertex core.
// ----------------------------------------------------------------------------
package scvg_pkg;

  typedef struct packed {
    logic [7:0] lat_deg;
    logic [8:0] lon_deg;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [2:0]         corner_slot;
    logic               last_vertex;
  } out_item_t;

  // Corner angles of one cell, as queued between front and back.
  typedef struct packed {
    logic [8:0] lat0;
    logic [8:0] lat1;
    logic [9:0] lon0;
    logic [9:0] lon1;
  } cell_t;

  // Register indexes
  localparam logic [2:0] REG_RADIUS   = 3'd0;
  localparam logic [2:0] REG_CENTER_X = 3'd1;
  localparam logic [2:0] REG_CENTER_Y = 3'd2;
  localparam logic [2:0] REG_CENTER_Z = 3'd3;
  localparam logic [2:0] REG_STEP_LAT = 3'd4;
  localparam logic [2:0] REG_STEP_LON = 3'd5;

  // Per-slot offset selects, bit k is slot k.
  localparam logic [5:0] SLOT_LAT = 6'b011001;
  localparam logic [5:0] SLOT_LON = 6'b001101;
  localparam logic [2:0] LAST_SLOT = 3'd5;

  localparam logic [16:0] TEX_ONE = 17'd65536;
  // ceil(2^30 / 90), exact for dividends below 2^23
  localparam logic [23:0] RECIP_90 = 24'd11930465;

  localparam logic [16:0] SIN_TAB [91] = '{
    17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
    17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
    17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
    17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
    17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
    17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
    17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
    17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
    17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
    17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
    17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
    17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
    17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // Reduce an angle below 1080 to 0..359.
  function automatic logic [8:0] mod360(input logic [10:0] a);
    logic [10:0] r;
    begin
      if (a >= 11'd720) begin
        r = a - 11'd720;
      end else if (a >= 11'd360) begin
        r = a - 11'd360;
      end else begin
        r = a;
      end
      return r[8:0];
    end
  endfunction

  // Quarter-wave sine, angle already in 0..359, Q1.16 signed.
  function automatic logic signed [17:0] sin_q(input logic [8:0] a);
    logic [8:0] idx;
    logic       neg;
    begin
      neg = 1'b0;
      if (a <= 9'd90) begin
        idx = a;
      end else if (a <= 9'd180) begin
        idx = 9'd180 - a;
      end else if (a <= 9'd270) begin
        idx = a - 9'd180;
        neg = 1'b1;
      end else begin
        idx = 9'd360 - a;
        neg = 1'b1;
      end
      return neg ? -$signed({1'b0, SIN_TAB[idx[6:0]]})
                 : $signed({1'b0, SIN_TAB[idx[6:0]]});
    end
  endfunction

  // floor(x / 90) for x below 2^23
  function automatic logic [16:0] div90(input logic [22:0] x);
    logic [46:0] p;
    begin
      p = x * RECIP_90;
      return p[46:30];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/scvg_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scvg_queue
// Two-entry queue of cell corner angles between front and back.
// ----------------------------------------------------------------------------
module scvg_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  scvg_pkg::cell_t      push_data_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 head_valid_o,
  output scvg_pkg::cell_t      head_o
);
  import scvg_pkg::*;

  cell_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q[1];
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[rtl/core/scvg_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scvg_front
// Takes input cells and forms both corner angles of each for the queue.
// ----------------------------------------------------------------------------
module scvg_front (
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  scvg_pkg::in_item_t   in_data_i,
  input  wire [7:0]            step_lat_i,
  input  wire [8:0]            step_lon_i,
  input  wire                  q_full_i,
  output logic                 push_o,
  output scvg_pkg::cell_t      push_data_o
);
  import scvg_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_data_o.lat0 = {1'b0, in_data_i.lat_deg};
    push_data_o.lat1 = {1'b0, in_data_i.lat_deg} + {1'b0, step_lat_i};
    push_data_o.lon0 = {1'b0, in_data_i.lon_deg};
    push_data_o.lon1 = {1'b0, in_data_i.lon_deg} + {1'b0, step_lon_i};
  end

endmodule
`default_nettype wire

[rtl/core/scvg_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scvg_back
// Walks six slots per cell through a four-stage vertex pipeline.
// ----------------------------------------------------------------------------
module scvg_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  head_valid_i,
  input  scvg_pkg::cell_t      head_i,
  output logic                 pop_o,
  input  wire [22:0]           radius_i,
  input  wire signed [23:0]    center_x_i,
  input  wire signed [23:0]    center_y_i,
  input  wire signed [23:0]    center_z_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output scvg_pkg::out_item_t  out_data_o
);
  import scvg_pkg::*;

  logic       adv;
  logic [2:0] slot_q, slot_d;
  logic [8:0] a_c;
  logic [9:0] b_c;
  logic [8:0] am, bm;

  // stage 1: trig values
  logic               v1_q;
  logic signed [17:0] sa_q, ca_q, sb_q, cb_q;
  logic [8:0]         a1_q;
  logic [9:0]         b1_q;
  logic [2:0]         s1_q;
  // stage 2: trig products and texture
  logic               v2_q;
  logic signed [35:0] px_q, py_q, pz_q;
  logic [16:0]        tu_q, tv_q;
  logic [2:0]         s2_q;
  logic [16:0]        tu_d, tv_d;
  // stage 3: scaled by radius
  logic               v3_q;
  logic signed [59:0] mx_q, my_q, mz_q;
  logic [16:0]        tu3_q, tv3_q;
  logic [2:0]         s3_q;
  // output register
  logic               vo_q;
  out_item_t          out_q, out_d;

  assign adv   = !vo_q || !out_stall_i;
  assign pop_o = adv && head_valid_i && (slot_q == LAST_SLOT);

  assign slot_d = !(adv && head_valid_i) ? slot_q :
                  (slot_q == LAST_SLOT)  ? 3'd0 : slot_q + 3'd1;

  assign a_c = SLOT_LAT[slot_q] ? head_i.lat1 : head_i.lat0;
  assign b_c = SLOT_LON[slot_q] ? head_i.lon1 : head_i.lon0;
  assign am  = mod360({2'b00, a_c});
  assign bm  = mod360({1'b0, b_c});

  always_comb begin
    if (b1_q >= 10'd360) begin
      tu_d = '0;
    end else begin
      tu_d = TEX_ONE - div90({b1_q[8:0], 14'd0} + 23'd45);
    end
    if (a1_q >= 9'd180) begin
      tv_d = TEX_ONE;
    end else begin
      tv_d = div90({a1_q[7:0], 15'd0} + 23'd45);
    end
  end

  function automatic logic signed [23:0] fin(input logic signed [59:0] m,
                                             input logic signed [23:0] c);
    logic signed [59:0] r;
    logic signed [28:0] s;
    begin
      r = m + (m[59] ? 60'sh0_7FFF_FFFF : 60'sh0_8000_0000);
      s = $signed(r[59:32]) + c;
      if (s > 29'sd8388607) begin
        return 24'sh7FFFFF;
      end else if (s < -29'sd8388608) begin
        return 24'sh800000;
      end else begin
        return s[23:0];
      end
    end
  endfunction

  always_comb begin
    out_d.pos_x       = fin(mx_q, center_x_i);
    out_d.pos_y       = fin(my_q, center_y_i);
    out_d.pos_z       = fin(mz_q, center_z_i);
    out_d.tex_u       = tu3_q;
    out_d.tex_v       = tv3_q;
    out_d.corner_slot = s3_q;
    out_d.last_vertex = s3_q == LAST_SLOT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 3'd0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vo_q   <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (adv) begin
        v1_q <= head_valid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q  <= sin_q(am);
      ca_q  <= sin_q(mod360({2'b00, am} + 11'd90));
      sb_q  <= sin_q(bm);
      cb_q  <= sin_q(mod360({2'b00, bm} + 11'd90));
      a1_q  <= a_c;
      b1_q  <= b_c;
      s1_q  <= slot_q;
      px_q  <= sa_q * cb_q;
      py_q  <= sa_q * sb_q;
      pz_q  <= {{2{ca_q[17]}}, ca_q, 16'd0};
      tu_q  <= tu_d;
      tv_q  <= tv_d;
      s2_q  <= s1_q;
      mx_q  <= $signed({1'b0, radius_i}) * px_q;
      my_q  <= $signed({1'b0, radius_i}) * py_q;
      mz_q  <= $signed({1'b0, radius_i}) * pz_q;
      tu3_q <= tu_q;
      tv3_q <= tv_q;
      s3_q  <= s2_q;
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[rtl/core/sphere_cell_vertex_generator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_cell_vertex_generator_core
// Six vertices (two triangles) of one UV sphere grid cell per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer names a cell by its corner angles in whole degrees; the
// core returns six vertex transfers in corner order (1,1)(0,0)(0,1)(1,1)(1,0)
// (0,0) of (lat, lon) step offsets, with corner_slot 0..5 and last_vertex on
// slot 5. Positions are center + radius * sin/cos products in signed Q7.16,
// rounded and saturated; tex_u = 1 - lon/360 and tex_v = lat/180 in Q1.16.
// Throughput is one vertex per clock while a cell is queued and the output
// does not stall, set by the single vertex pipeline in the back end. Cells
// pass the queue, then the pipeline registers. A two-entry cell queue sits
// between front and back end; input goes on while outputs stall, until full.
// Registers sit on an APB port at byte offsets 0x00 radius, 0x04..0x0C
// center x/y/z, 0x10 step_lat, 0x14 step_lon; write them only while idle.
// ----------------------------------------------------------------------------
module sphere_cell_vertex_generator_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [4:0]            paddr,
  input  wire [31:0]           pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  scvg_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output scvg_pkg::out_item_t  out_data_o
);
  import scvg_pkg::*;

  logic [22:0]        radius_q;
  logic signed [23:0] center_x_q, center_y_q, center_z_q;
  logic [7:0]         step_lat_q;
  logic [8:0]         step_lon_q;
  logic               wr_en;
  logic [2:0]         reg_idx;

  logic  q_full, push, pop, head_valid;
  cell_t push_data, head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register write; unknown offsets are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= 23'd262144;
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      step_lat_q <= 8'd1;
      step_lon_q <= 9'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RADIUS:   radius_q   <= pwdata[22:0];
        REG_CENTER_X: center_x_q <= pwdata[23:0];
        REG_CENTER_Y: center_y_q <= pwdata[23:0];
        REG_CENTER_Z: center_z_q <= pwdata[23:0];
        REG_STEP_LAT: step_lat_q <= pwdata[7:0];
        REG_STEP_LON: step_lon_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIUS:   prdata = {9'd0, radius_q};
      REG_CENTER_X: prdata = {{8{center_x_q[23]}}, center_x_q};
      REG_CENTER_Y: prdata = {{8{center_y_q[23]}}, center_y_q};
      REG_CENTER_Z: prdata = {{8{center_z_q[23]}}, center_z_q};
      REG_STEP_LAT: prdata = {24'd0, step_lat_q};
      REG_STEP_LON: prdata = {23'd0, step_lon_q};
      default:      prdata = '0;
    endcase
  end

  scvg_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .step_lat_i  (step_lat_q),
    .step_lon_i  (step_lon_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  scvg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  scvg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .radius_i     (radius_q),
    .center_x_i   (center_x_q),
    .center_y_i   (center_y_q),
    .center_z_i   (center_z_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

[tb/tb_sphere_cell_vertex_generator_core.sv]
// ----------------------------------------------------------------------------
// tb_sphere_cell_vertex_generator_core
// Self-checking bench: cell corner transfers in, six predicted vertices out.
// ----------------------------------------------------------------------------
// A queue of cells feeds a clocked driver; a clocked monitor compares every
// vertex transfer against the oldest predicted vertex. Registers are written
// over APB between phases, only once the core has drained.
// ----------------------------------------------------------------------------
module tb_sphere_cell_vertex_generator_core;
  import scvg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 60;

  // Quarter-wave table, round(sin(d) * 65536), d = 0..90
  localparam int SINE_Q16 [91] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  sphere_cell_vertex_generator_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the geometry registers
  int unsigned  sh_radius = 262144;
  int           sh_cx = 0, sh_cy = 0, sh_cz = 0;
  int unsigned  sh_step_lat = 1, sh_step_lon = 1;

  in_item_t     pending_cells[$];
  out_item_t    expected_vertices[$];
  int           error_count = 0;
  int           vertex_count = 0;
  int           cell_count = 0;
  int           idle_cycles = 0;
  int           hold_count = 0;     // receiver hold-off cycles spent so far
  bit           calm_mode = 1'b0;   // no random idling on either side
  bit           hold_rx = 1'b0;     // receiver hold-off request
  bit           stim_done = 1'b0;

  function automatic int sine_deg(int unsigned a);
    a = a % 360;
    if (a <= 90)  return SINE_Q16[a];
    if (a <= 180) return SINE_Q16[180 - a];
    if (a <= 270) return -SINE_Q16[a - 180];
    return -SINE_Q16[360 - a];
  endfunction

  // center + round(radius * t1 * t2 / 2^32), ties away from zero, saturated
  function automatic logic signed [23:0] vertex_coord(int center, int t1, int t2);
    longint p, m, s;
    p = longint'(sh_radius) * longint'(t1) * longint'(t2);
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 <<< 31)) >>> 32;
    s = longint'(center) + ((p < 0) ? -m : m);
    if (s > 8388607)  s = 8388607;
    if (s < -8388608) s = -8388608;
    return s[23:0];
  endfunction

  task automatic predict_cell_vertices(in_item_t c);
    logic [5:0]  lat_sel, lon_sel;
    int unsigned a, b;
    int          sa, ca, sb, cb;
    out_item_t   v;
    lat_sel = 6'b011001;
    lon_sel = 6'b001101;
    for (int k = 0; k < 6; k++) begin
      a  = c.lat_deg + (lat_sel[k] ? sh_step_lat : 0);
      b  = c.lon_deg + (lon_sel[k] ? sh_step_lon : 0);
      sa = sine_deg(a);
      ca = sine_deg(a % 360 + 90);
      sb = sine_deg(b);
      cb = sine_deg(b % 360 + 90);
      v.pos_x = vertex_coord(sh_cx, sa, cb);
      v.pos_y = vertex_coord(sh_cy, sa, sb);
      v.pos_z = vertex_coord(sh_cz, ca, 65536);
      v.tex_u = (b >= 360) ? 17'd0 : 17'(65536 - (longint'(b) * 65536 + 180) / 360);
      v.tex_v = (a >= 180) ? 17'd65536 : 17'((longint'(a) * 65536 + 90) / 180);
      v.corner_slot = 3'(k);
      v.last_vertex = (k == 5);
      expected_vertices = {expected_vertices, v};
    end
  endtask

  // Driver: one nonblocking update of valid and data per edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_cell_vertices(in_data_i);
        cell_count++;
        void'(pending_cells.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if ((in_valid_i && !in_stall_o ? pending_cells.size() > 0
                                       : pending_cells.size() > 0) &&
            (calm_mode || $urandom_range(99) >= 19)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_cells[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall; a hold-off request is counted out here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        vertex_count++;
        if (expected_vertices.size() == 0) begin
          error_count++;
          $display("%0t: unexpected vertex %p", $time, out_data_o);
        end else begin
          out_item_t e;
          e = expected_vertices.pop_front();
          if (e !== out_data_o) begin
            error_count++;
            $display("%0t: vertex mismatch expected %p actual %p", $time, e, out_data_o);
          end
        end
      end
      if (hold_rx && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
      out_stall_i <= (hold_rx && hold_count < HOLD_CYCLES) ||
                     (!calm_mode && $urandom_range(99) < 19);
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else if (pending_cells.size() > 0 || expected_vertices.size() > 0 || !stim_done)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cells.size() > 0 || in_valid_i || expected_vertices.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RADIUS:   sh_radius   = value[22:0];
      REG_CENTER_X: sh_cx       = int'($signed(value[23:0]));
      REG_CENTER_Y: sh_cy       = int'($signed(value[23:0]));
      REG_CENTER_Z: sh_cz       = int'($signed(value[23:0]));
      REG_STEP_LAT: sh_step_lat = value[7:0];
      REG_STEP_LON: sh_step_lon = value[8:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned r, int x, int y, int z,
                              int unsigned sl, int unsigned sn);
    reg_write(REG_RADIUS, r);
    reg_write(REG_CENTER_X, x);
    reg_write(REG_CENTER_Y, y);
    reg_write(REG_CENTER_Z, z);
    reg_write(REG_STEP_LAT, sl);
    reg_write(REG_STEP_LON, sn);
  endtask

  task automatic queue_cell(int unsigned lat, int unsigned lon);
    in_item_t c;
    c.lat_deg = lat[7:0];
    c.lon_deg = lon[8:0];
    pending_cells = {pending_cells, c};
  endtask

  task automatic queue_random_cells(int n);
    for (int i = 0; i < n; i++) begin
      // full field range now and then, so every input bit toggles
      if ($urandom_range(9) == 0) queue_cell($urandom_range(255), $urandom_range(511));
      else queue_cell($urandom_range(179), $urandom_range(359));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default registers, corner angles and boundaries
    calm_mode = 1'b1;
    queue_cell(0, 0);   queue_cell(179, 359); queue_cell(90, 180);
    queue_cell(89, 90); queue_cell(45, 270);  queue_cell(255, 511);
    wait_drained();

    // Large steps push corners past 180 / 360: wrap in trig, clamp in texture
    set_geometry(23'h7FFFFF, 24'h7FFFFF, 24'h800000, 0, 180, 360);
    queue_cell(179, 359); queue_cell(0, 0); queue_cell(90, 300);
    queue_cell(170, 200); queue_cell(255, 511);
    wait_drained();

    // Degenerate cell with zero steps, zero radius
    set_geometry(0, 24'h123456, 24'hFEDCBA, 24'h800000, 0, 0);
    queue_cell(30, 60); queue_cell(179, 359);
    wait_drained();

    // Random phase one: moderate geometry, random idling
    calm_mode = 1'b0;
    set_geometry(262144, -65536, 131072, 0, 10, 15);
    queue_random_cells(40);
    wait_drained();

    // Receiver holds off while the sender keeps offering: core fills and stalls
    hold_rx = 1'b1;
    queue_random_cells(10);
    wait (hold_count >= HOLD_CYCLES);
    hold_rx = 1'b0;
    wait_drained();

    // Random geometry; first a stretch with no idling at all
    set_geometry($urandom_range(8388607), $urandom, $urandom, $urandom,
                 $urandom_range(1, 180), $urandom_range(1, 360));
    calm_mode = 1'b1;
    queue_random_cells(30);
    wait_drained();
    calm_mode = 1'b0;
    set_geometry(8388607, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 1);
    queue_random_cells(40);
    wait_drained();

    stim_done = 1'b1;
    $display("Covered %0d cells, %0d vertices over several register settings,",
             cell_count, vertex_count);
    $display("including wrap, clamp, saturation, zero-step and back-pressure cases.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
